[design/bhpq_pkg.sv]
package bhpq_pkg;

    localparam int DEPTH      = 1024;
    localparam int KEY_WIDTH  = 32;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_WIDTH = $clog2(DEPTH + 1);
    localparam int CNT_WIDTH  = 11;
    localparam int QDEPTH     = 2;

    typedef enum logic [1:0]
    {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_PEEK    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef struct packed
    {
        op_t                   op;
        logic [KEY_WIDTH-1:0]  key;
        logic [DATA_WIDTH-1:0] payload;
    } cmd_t;

    typedef struct packed
    {
        logic [1:0]  status;
        logic [31:0] top_key;
        logic [31:0] top_payload;
        logic [10:0] entry_count;
    } res_t;

endpackage

[design/bhpq_if.sv]
interface bhpq_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] key;
    logic [31:0] payload;
    modport source (output valid, operation, key, payload, input ready);
    modport sink (input valid, operation, key, payload, output ready);
endinterface

interface bhpq_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] top_key;
    logic [31:0] top_payload;
    logic [10:0] entry_count;
    modport source (output valid, status, top_key, top_payload, entry_count, input ready);
    modport sink (input valid, status, top_key, top_payload, entry_count, output ready);
endinterface

[design/bhpq_front.sv]
module bhpq_front
(
    input  logic          clk,
    input  logic          rst_n,
    bhpq_cmd_if.sink      cmd,
    output bhpq_pkg::cmd_t q_data,
    output logic          q_valid,
    input  logic          q_pop
);
    import bhpq_pkg::*;

    cmd_t                  fifo_reg [QDEPTH];
    logic [1:0]            cnt_reg, cnt_next;
    logic                  rd_reg, wr_reg;
    logic                  push;

    assign cmd.ready = (cnt_reg < 2'(QDEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_data    = fifo_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= ~wr_reg;
            if (q_pop)
                rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_reg].op      <= op_t'(cmd.operation);
            fifo_reg[wr_reg].key     <= cmd.key;
            fifo_reg[wr_reg].payload <= cmd.payload;
        end
    end

endmodule

[design/bhpq_back.sv]
module bhpq_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           order_mode,
    input  bhpq_pkg::cmd_t q_data,
    input  logic           q_valid,
    output logic           q_pop,
    bhpq_res_if.source     res
);
    import bhpq_pkg::*;

    typedef enum logic [7:0]
    {
        S_IDLE  = 8'b0000_0001,
        S_UPRD  = 8'b0000_0010,
        S_UPCMP = 8'b0000_0100,
        S_LSTRD = 8'b0000_1000,
        S_DNRD  = 8'b0001_0000,
        S_DNL   = 8'b0010_0000,
        S_DNCMP = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    localparam int EW = KEY_WIDTH + DATA_WIDTH;

    logic [EW-1:0]         mem [DEPTH+1];
    logic [EW-1:0]         rdata_reg;
    logic [ADDR_WIDTH-1:0] raddr;
    logic                  re;
    logic [ADDR_WIDTH-1:0] waddr;
    logic [EW-1:0]         wdata;
    logic                  we;

    state_t                state_reg, state_next;
    logic [CNT_WIDTH-1:0]  count_reg, count_next;
    logic [ADDR_WIDTH:0]   idx_reg, idx_next;
    logic [EW-1:0]         cur_reg, cur_next;
    logic [EW-1:0]         best_reg, best_next;
    logic [ADDR_WIDTH:0]   bidx_reg, bidx_next;
    res_t                  out_reg, out_next;
    logic                  ov_reg, ov_next;

    logic [ADDR_WIDTH:0]   lidx, ridx;

    function automatic logic beats(input logic mode, input logic [EW-1:0] a,
                                   input logic [EW-1:0] b);
        logic [KEY_WIDTH-1:0] ka, kb;
        ka = a[EW-1 -: KEY_WIDTH];
        kb = b[EW-1 -: KEY_WIDTH];
        return mode ? (ka < kb) : (ka > kb);
    endfunction

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign lidx = {idx_reg[ADDR_WIDTH-1:0], 1'b0};
    assign ridx = {idx_reg[ADDR_WIDTH-1:0], 1'b1};

    assign res.valid       = ov_reg;
    assign res.status      = out_reg.status;
    assign res.top_key     = out_reg.top_key;
    assign res.top_payload = out_reg.top_payload;
    assign res.entry_count = out_reg.entry_count;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        best_next  = best_reg;
        bidx_next  = bidx_reg;
        out_next   = out_reg;
        ov_next    = ov_reg;
        q_pop      = 1'b0;
        re         = 1'b0;
        raddr      = '0;
        we         = 1'b0;
        waddr      = '0;
        wdata      = cur_reg;
        if (res.valid && res.ready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !ov_next)
                begin
                    q_pop      = 1'b1;
                    out_next   = '{status: ST_OK, top_key: '0, top_payload: '0,
                                   entry_count: count_reg};
                    case (q_data.op)
                        OP_INSERT:
                        begin
                            if (count_reg >= CNT_WIDTH'(DEPTH))
                            begin
                                out_next.status = ST_FULL;
                                ov_next         = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                idx_next   = (ADDR_WIDTH+1)'(count_reg + 1'b1);
                                cur_next   = {q_data.key, q_data.payload};
                                out_next.entry_count = count_reg + 1'b1;
                                state_next = S_UPRD;
                            end
                        end
                        OP_EXTRACT, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                out_next.status = ST_EMPTY;
                                ov_next         = 1'b1;
                            end
                            else
                            begin
                                re    = 1'b1;
                                raddr = ADDR_WIDTH'(1);
                                if (q_data.op == OP_EXTRACT)
                                begin
                                    count_next = count_reg - 1'b1;
                                    out_next.entry_count = count_reg - 1'b1;
                                end
                                state_next = S_LSTRD;
                                idx_next   = {1'b0, q_data.op == OP_EXTRACT,
                                              {(ADDR_WIDTH-1){1'b0}}};
                            end
                        end
                        default:
                        begin
                            ov_next = 1'b1;
                        end
                    endcase
                end
            end
            S_UPRD:
            begin
                if (idx_reg <= (ADDR_WIDTH+1)'(1))
                begin
                    we         = 1'b1;
                    waddr      = idx_reg[ADDR_WIDTH-1:0];
                    state_next = S_OUT;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = idx_reg[ADDR_WIDTH:1];
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                we    = 1'b1;
                waddr = idx_reg[ADDR_WIDTH-1:0];
                if (beats(order_mode, cur_reg, rdata_reg))
                begin
                    wdata      = rdata_reg;
                    idx_next   = idx_reg >> 1;
                    state_next = S_UPRD;
                end
                else
                begin
                    wdata      = cur_reg;
                    state_next = S_OUT;
                end
            end
            S_LSTRD:
            begin
                out_next.top_key     = rdata_reg[EW-1 -: KEY_WIDTH];
                out_next.top_payload = rdata_reg[DATA_WIDTH-1:0];
                if (idx_reg[ADDR_WIDTH-1] == 1'b0 || count_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = ADDR_WIDTH'(count_reg + 1'b1);
                    idx_next   = (ADDR_WIDTH+1)'(1);
                    bidx_next  = '0;
                    state_next = S_DNRD;
                end
            end
            S_DNRD:
            begin
                if (idx_reg == (ADDR_WIDTH+1)'(1) && bidx_reg != (ADDR_WIDTH+1)'(1))
                    cur_next = rdata_reg;
                bidx_next = (ADDR_WIDTH+1)'(1);
                if (lidx > (ADDR_WIDTH+1)'(count_reg))
                begin
                    we         = 1'b1;
                    waddr      = idx_reg[ADDR_WIDTH-1:0];
                    wdata      = (idx_reg == (ADDR_WIDTH+1)'(1) &&
                                  bidx_reg != (ADDR_WIDTH+1)'(1)) ? rdata_reg : cur_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = lidx[ADDR_WIDTH-1:0];
                    state_next = S_DNL;
                end
            end
            S_DNL:
            begin
                if (beats(order_mode, rdata_reg, cur_reg))
                begin
                    best_next = rdata_reg;
                    bidx_next = lidx;
                end
                else
                begin
                    best_next = cur_reg;
                    bidx_next = idx_reg;
                end
                if (ridx <= (ADDR_WIDTH+1)'(count_reg))
                begin
                    re         = 1'b1;
                    raddr      = ridx[ADDR_WIDTH-1:0];
                    state_next = S_DNCMP;
                end
                else
                begin
                    state_next = S_DNCMP;
                    bidx_next  = beats(order_mode, rdata_reg, cur_reg) ? lidx : idx_reg;
                    best_next  = beats(order_mode, rdata_reg, cur_reg) ? rdata_reg : cur_reg;
                    idx_next   = idx_reg | {1'b1, {ADDR_WIDTH{1'b0}}};
                end
            end
            S_DNCMP:
            begin
                logic [ADDR_WIDTH:0]   bi;
                logic [EW-1:0]         bv;
                logic [ADDR_WIDTH:0]   ii;
                ii = {1'b0, idx_reg[ADDR_WIDTH-1:0]};
                bi = bidx_reg;
                bv = best_reg;
                if (!idx_reg[ADDR_WIDTH] && beats(order_mode, rdata_reg, best_reg))
                begin
                    bi = ridx;
                    bv = rdata_reg;
                end
                we    = 1'b1;
                waddr = ii[ADDR_WIDTH-1:0];
                if (bi == ii)
                begin
                    wdata      = cur_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    wdata      = bv;
                    idx_next   = bi;
                    bidx_next  = (ADDR_WIDTH+1)'(1);
                    state_next = S_DNRD;
                end
            end
            S_OUT:
            begin
                if (!ov_next)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
            bidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            bidx_reg  <= bidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        cur_reg  <= cur_next;
        best_reg <= best_next;
        out_reg  <= out_next;
    end

endmodule

[design/binary_heap_priority_queue_unit.sv]
// Priority queue on a binary heap of up to 1024 key and payload pairs.
// The cmd channel takes one operation a beat: insert, extract top or peek top.
// The res channel gives one beat for each operation, with a status, the top
// pair for extract and peek, and the entry count after the operation.
// A two-entry queue sits between the command front end and the heap engine,
// so commands are taken while the engine works or a result waits.
// The engine takes a command from the queue at the earliest in the cycle after
// its cmd beat. The heap sits in a memory with one read and one write a
// cycle. Insert lets the new entry climb one level at a time until it stops
// below a parent that it does not beat; extract lets the last entry sink
// one level at a time from the root until no child beats it.
// order_mode selects a max-heap at 0 and a min-heap at 1; write it only
// while the block is idle.
// Reset empties the heap and selects max-heap order; memory contents are
// not cleared. When the receiver holds off res.ready, the result stays and
// the engine waits before it starts the next command.
module binary_heap_priority_queue_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    bhpq_cmd_if.sink   cmd,
    bhpq_res_if.source res
);
    import bhpq_pkg::*;

    cmd_t q_data;
    logic q_valid;
    logic q_pop;
    logic order_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_mode_reg <= 1'b0;
        else if (cfg_we)
            order_mode_reg <= cfg_wdata;
    end

    bhpq_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    bhpq_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .order_mode (order_mode_reg),
        .q_data     (q_data),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .res        (res)
    );

endmodule

[design/bhpq_checker.sv]
module bhpq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  status,
    input logic [31:0] top_key,
    input logic [10:0] entry_count
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(entry_count))
        else $error("result beat dropped while stalled");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> entry_count <= 11'd1024)
        else $error("entry count out of range");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == 2'd1 |-> entry_count == 11'd0 && top_key == 32'd0)
        else $error("empty status with entries");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == 2'd2 |-> entry_count == 11'd1024)
        else $error("full status below capacity");
endmodule

bind binary_heap_priority_queue_unit bhpq_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .status      (res.status),
    .top_key     (res.top_key),
    .entry_count (res.entry_count)
);
